// ===== rtl/alc_pkg.sv =====
// ----------------------------------------------------------------------------
// Array list engine package
// Shared types, codes and field widths for the list engine and its cells.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int OP_W  = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 31;
  localparam int ST_W  = 3;
  localparam int CNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_MAX    = 3'd4,
    OP_READ   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_INDEX = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_NO_MATCH  = 3'd4
  } status_t;

  // Command that every cell carries out at the clock edge.
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_ROTATE = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t              cmd;
    logic [POS_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
    logic [VAL_W-1:0]       val;
  } alc_ctl_t;

endpackage

// ===== rtl/alc_cell.sv =====
// ----------------------------------------------------------------------------
// Array list cell
// Holds one list word and takes a neighbor's word on shifts and rotations.
// ----------------------------------------------------------------------------
module alc_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  alc_pkg::alc_ctl_t         ctl,
  input  logic [alc_pkg::VAL_W-1:0] left,
  input  logic [alc_pkg::VAL_W-1:0] right,
  output logic [alc_pkg::VAL_W-1:0] word
);
  import alc_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

  logic [CNT_W-1:0] pos_c;
  logic [VAL_W-1:0] word_next;

  assign pos_c = CNT_W'(ctl.pos);

  always_comb begin
    word_next = word;
    case (ctl.cmd)
      CMD_APPEND: begin
        if (IDX_C == ctl.count) word_next = ctl.val;
      end
      CMD_INSERT: begin
        if (IDX_C == pos_c) begin
          word_next = ctl.val;
        end else if (IDX_C > pos_c && IDX_C <= ctl.count) begin
          word_next = left;
        end
      end
      CMD_DELETE: begin
        if (IDX_C >= pos_c && NEXT_C < ctl.count) word_next = right;
      end
      CMD_ROTATE: word_next = right;
      default:    word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== rtl/array_list_engine.sv =====
// ----------------------------------------------------------------------------
// Array list engine
// Bounded ordered list of 31-bit words held in a row of cells.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid / in_stall) with an
// operation, a position and a value. Results leave on the output channel
// (out_valid / out_stall); the last result of a request has last_result set.
// Append, insert, delete, clear and rejected requests finish in the cycle
// they are accepted and show their result in the next cycle. Insert and delete
// move the whole tail in the accepting cycle, every cell taking its neighbor.
// Search, max pair and read rotate the row of cells past cell 0 once in
// DEPTH steps, then register the final result from the done state.
// Search emits earlier matches during the rotation.
// One request is in work at a time; the next can be accepted at the edge
// where the previous final result leaves the output register.
// A stall on the output freezes the rotation and holds the output register.
// Reset empties the list and drops any result in flight; stored words
// are not cleared.
// ----------------------------------------------------------------------------
module array_list_engine #(
  parameter int DEPTH = alc_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [alc_pkg::OP_W-1:0]  operation,
  input  logic [alc_pkg::POS_W-1:0] position,
  input  logic [alc_pkg::VAL_W-1:0] item_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [alc_pkg::ST_W-1:0]  status,
  output logic [alc_pkg::VAL_W-1:0] result_value,
  output logic [alc_pkg::VAL_W-1:0] second_value,
  output logic [alc_pkg::POS_W-1:0] match_index,
  output logic [alc_pkg::CNT_W-1:0] count_after,
  output logic                      last_result
);
  import alc_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [IW-1:0]    KLAST   = IW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state;
  logic [CW-1:0]    count;
  logic [IW-1:0]    k;
  op_t              sop;
  logic [VAL_W-1:0] sval;
  logic [IW-1:0]    spos;
  logic [VAL_W-1:0] m1;
  logic [VAL_W-1:0] m2;
  logic [VAL_W-1:0] rdv;
  logic             pend_valid;
  logic [IW-1:0]    pend_idx;

  logic             ovalid;
  status_t          ostatus;
  logic [VAL_W-1:0] orv;
  logic [VAL_W-1:0] osv;
  logic [POS_W-1:0] omi;
  logic [CNT_W-1:0] ocount;
  logic             olast;

  logic             out_free;
  logic             accept;
  logic [CNT_W-1:0] cnt_c;
  logic [CNT_W-1:0] pos_c;
  logic             empty;
  logic             full;
  logic             bad;
  logic             in_range;
  logic [VAL_W-1:0] head;
  alc_ctl_t         ctl;
  logic [VAL_W-1:0] word [DEPTH];

  assign out_free = !ovalid || !out_stall;
  assign in_stall = !(state == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;

  assign cnt_c    = CNT_W'(count);
  assign pos_c    = CNT_W'(position);
  assign empty    = (count == '0);
  assign full     = (cnt_c >= DEPTH_C);
  assign bad      = (pos_c >= cnt_c);
  assign in_range = (CW'(k) < count);
  assign head     = word[0];

  // Command broadcast to all cells.
  always_comb begin
    ctl.cmd   = CMD_NONE;
    ctl.pos   = position;
    ctl.count = cnt_c;
    ctl.val   = item_value;
    if (state == S_IDLE && accept) begin
      case (op_t'(operation))
        OP_APPEND: if (!full) ctl.cmd = CMD_APPEND;
        OP_INSERT: if (!empty && !bad && !full) ctl.cmd = CMD_INSERT;
        OP_DELETE: if (!empty && !bad) ctl.cmd = CMD_DELETE;
        default:   ctl.cmd = CMD_NONE;
      endcase
    end else if (state == S_SCAN && out_free) begin
      ctl.cmd = CMD_ROTATE;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    alc_cell #(
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .left  (word[(i == 0) ? 0 : i - 1]),
      .right (word[(i + 1) % DEPTH]),
      .word  (word[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ovalid     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (ovalid && !out_stall) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            ovalid  <= 1'b1;
            ostatus <= STAT_OK;
            orv     <= '0;
            osv     <= '0;
            omi     <= '0;
            olast   <= 1'b1;
            ocount  <= cnt_c;
            case (op_t'(operation))
              OP_APPEND: begin
                if (full) begin
                  ostatus <= STAT_FULL;
                end else begin
                  count  <= count + 1'b1;
                  ocount <= cnt_c + 1'b1;
                end
              end
              OP_INSERT: begin
                if (empty) begin
                  ostatus <= STAT_EMPTY;
                end else if (bad) begin
                  ostatus <= STAT_BAD_INDEX;
                end else if (full) begin
                  ostatus <= STAT_FULL;
                end else begin
                  count  <= count + 1'b1;
                  ocount <= cnt_c + 1'b1;
                end
              end
              OP_DELETE: begin
                if (empty) begin
                  ostatus <= STAT_EMPTY;
                end else if (bad) begin
                  ostatus <= STAT_BAD_INDEX;
                end else begin
                  count  <= count - 1'b1;
                  ocount <= cnt_c - 1'b1;
                end
              end
              OP_SEARCH, OP_MAX, OP_READ: begin
                if (empty) begin
                  ostatus <= STAT_EMPTY;
                end else if (op_t'(operation) == OP_READ && bad) begin
                  ostatus <= STAT_BAD_INDEX;
                end else begin
                  // The result comes after the rotation.
                  ovalid     <= 1'b0;
                  state      <= S_SCAN;
                  k          <= '0;
                  sop        <= op_t'(operation);
                  sval       <= item_value;
                  spos       <= IW'(position);
                  pend_valid <= 1'b0;
                end
              end
              OP_CLEAR: begin
                count  <= '0;
                ocount <= '0;
              end
              default: ostatus <= STAT_OK;
            endcase
          end
        end
        S_SCAN: begin
          if (out_free) begin
            k <= k + 1'b1;
            if (k == KLAST) state <= S_DONE;
            case (sop)
              OP_SEARCH: begin
                // A match is held back until the next one shows it is not the last.
                if (in_range && head == sval) begin
                  if (pend_valid) begin
                    ovalid  <= 1'b1;
                    ostatus <= STAT_OK;
                    orv     <= '0;
                    osv     <= '0;
                    omi     <= POS_W'(pend_idx);
                    ocount  <= cnt_c;
                    olast   <= 1'b0;
                  end
                  pend_valid <= 1'b1;
                  pend_idx   <= k;
                end
              end
              OP_MAX: begin
                if (k == '0) begin
                  m1 <= head;
                  m2 <= '0;
                end else if (in_range) begin
                  if (head > m1) begin
                    m2 <= m1;
                    m1 <= head;
                  end else if (head > m2) begin
                    m2 <= head;
                  end
                end
              end
              OP_READ: begin
                if (k == spos) rdv <= head;
              end
              default: rdv <= rdv;
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            state   <= S_IDLE;
            ovalid  <= 1'b1;
            ostatus <= STAT_OK;
            orv     <= '0;
            osv     <= '0;
            omi     <= '0;
            ocount  <= cnt_c;
            olast   <= 1'b1;
            case (sop)
              OP_SEARCH: begin
                if (pend_valid) begin
                  omi <= POS_W'(pend_idx);
                end else begin
                  ostatus <= STAT_NO_MATCH;
                end
              end
              OP_MAX: begin
                orv <= m1;
                osv <= m2;
              end
              OP_READ: orv <= rdv;
              default: orv <= '0;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = ovalid;
  assign status       = ostatus;
  assign result_value = orv;
  assign second_value = osv;
  assign match_index  = omi;
  assign count_after  = ocount;
  assign last_result  = olast;

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state register is not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (rst) cnt_c <= DEPTH_C)
    else $error("list length exceeds the depth");

  a_scan_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> $stable(count))
    else $error("list length changed during a rotation");

  a_partial_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_result) |-> (status == STAT_OK))
    else $error("non-final result without ok status");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && last_result))
    else $error("final result missing after rotation");

endmodule
